FILE: design/imadec_pkg.sv
// ----------------------------------------------------------------------------
// imadec_pkg
// Shared types, constants and tables for the IMA ADPCM nibble decoder.
// ----------------------------------------------------------------------------
package imadec_pkg;

  localparam int unsigned SAMPLE_W = 16;
  localparam int unsigned IDX_W    = 7;
  localparam int unsigned STEP_W   = 15;
  localparam int unsigned CHANS    = 2;

  localparam logic [IDX_W-1:0] IDX_MAX = 7'd88;

  localparam logic signed [SAMPLE_W-1:0] SAMPLE_MAX = 16'sh7FFF;
  localparam logic signed [SAMPLE_W-1:0] SAMPLE_MIN = 16'sh8000;

  // controller states, one-hot
  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_LO   = 3'b010,
    ST_HI   = 3'b100
  } state_t;

  // controller -> datapath commands
  typedef struct packed {
    logic latch_in;  // capture the input beat
    logic step_lo;   // decode low nibble, commit channel state
    logic load_out;  // decode high nibble, commit state, fill output register
  } dp_cmd_t;

  // index adjustment per nibble magnitude
  function automatic logic signed [4:0] idx_adjust(input logic [2:0] mag);
    logic signed [4:0] adj;
    case (mag)
      3'd4:    adj = 5'sd2;
      3'd5:    adj = 5'sd4;
      3'd6:    adj = 5'sd6;
      3'd7:    adj = 5'sd8;
      default: adj = -5'sd1;
    endcase
    return adj;
  endfunction

  // quantiser step size per index; indices above 88 read the top entry
  function automatic logic [STEP_W-1:0] step_size(input logic [IDX_W-1:0] idx);
    logic [STEP_W-1:0] s;
    case (idx)
      7'd0:  s = 15'd7;     7'd1:  s = 15'd8;     7'd2:  s = 15'd9;
      7'd3:  s = 15'd10;    7'd4:  s = 15'd11;    7'd5:  s = 15'd12;
      7'd6:  s = 15'd13;    7'd7:  s = 15'd14;    7'd8:  s = 15'd16;
      7'd9:  s = 15'd17;    7'd10: s = 15'd19;    7'd11: s = 15'd21;
      7'd12: s = 15'd23;    7'd13: s = 15'd25;    7'd14: s = 15'd28;
      7'd15: s = 15'd31;    7'd16: s = 15'd34;    7'd17: s = 15'd37;
      7'd18: s = 15'd41;    7'd19: s = 15'd45;    7'd20: s = 15'd50;
      7'd21: s = 15'd55;    7'd22: s = 15'd60;    7'd23: s = 15'd66;
      7'd24: s = 15'd73;    7'd25: s = 15'd80;    7'd26: s = 15'd88;
      7'd27: s = 15'd97;    7'd28: s = 15'd107;   7'd29: s = 15'd118;
      7'd30: s = 15'd130;   7'd31: s = 15'd143;   7'd32: s = 15'd157;
      7'd33: s = 15'd173;   7'd34: s = 15'd190;   7'd35: s = 15'd209;
      7'd36: s = 15'd230;   7'd37: s = 15'd253;   7'd38: s = 15'd279;
      7'd39: s = 15'd307;   7'd40: s = 15'd337;   7'd41: s = 15'd371;
      7'd42: s = 15'd408;   7'd43: s = 15'd449;   7'd44: s = 15'd494;
      7'd45: s = 15'd544;   7'd46: s = 15'd598;   7'd47: s = 15'd658;
      7'd48: s = 15'd724;   7'd49: s = 15'd796;   7'd50: s = 15'd876;
      7'd51: s = 15'd963;   7'd52: s = 15'd1060;  7'd53: s = 15'd1166;
      7'd54: s = 15'd1282;  7'd55: s = 15'd1411;  7'd56: s = 15'd1552;
      7'd57: s = 15'd1707;  7'd58: s = 15'd1878;  7'd59: s = 15'd2066;
      7'd60: s = 15'd2272;  7'd61: s = 15'd2499;  7'd62: s = 15'd2749;
      7'd63: s = 15'd3024;  7'd64: s = 15'd3327;  7'd65: s = 15'd3660;
      7'd66: s = 15'd4026;  7'd67: s = 15'd4428;  7'd68: s = 15'd4871;
      7'd69: s = 15'd5358;  7'd70: s = 15'd5894;  7'd71: s = 15'd6484;
      7'd72: s = 15'd7132;  7'd73: s = 15'd7845;  7'd74: s = 15'd8630;
      7'd75: s = 15'd9493;  7'd76: s = 15'd10442; 7'd77: s = 15'd11487;
      7'd78: s = 15'd12635; 7'd79: s = 15'd13899; 7'd80: s = 15'd15289;
      7'd81: s = 15'd16818; 7'd82: s = 15'd18500; 7'd83: s = 15'd20350;
      7'd84: s = 15'd22385; 7'd85: s = 15'd24623; 7'd86: s = 15'd27086;
      7'd87: s = 15'd29794;
      default: s = 15'd32767;
    endcase
    return s;
  endfunction

endpackage

FILE: design/imadec_ctrl.sv
// ----------------------------------------------------------------------------
// imadec_ctrl
// Sequencer: steps the datapath through low and high nibble, owns out_valid.
// ----------------------------------------------------------------------------
module imadec_ctrl
  import imadec_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    in_valid,
  output logic    in_ready,
  output logic    out_valid,
  input  logic    out_ready,
  output dp_cmd_t cmd
);

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   load_out;
  logic   accept;

  // high nibble may only finish when the output register is free or draining
  assign load_out = (state_r == ST_HI) && (!out_valid_r || out_ready);
  assign in_ready = (state_r == ST_IDLE) || load_out;
  assign accept   = in_valid && in_ready;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (accept) state_nxt = ST_LO;
      end
      ST_LO: begin
        state_nxt = ST_HI;
      end
      ST_HI: begin
        if (load_out) state_nxt = accept ? ST_LO : ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (load_out)       out_valid_nxt = 1'b1;
    else if (out_ready) out_valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid    = out_valid_r;
  assign cmd.latch_in = accept;
  assign cmd.step_lo  = (state_r == ST_LO);
  assign cmd.load_out = load_out;

endmodule

FILE: design/imadec_dp.sv
// ----------------------------------------------------------------------------
// imadec_dp
// Datapath: input latch, per-channel state, one shared nibble decoder,
// output register.
// ----------------------------------------------------------------------------
module imadec_dp
  import imadec_pkg::*;
(
  input  logic                       clk,
  input  logic                       rst_n,
  input  dp_cmd_t                    cmd,
  input  logic [7:0]                 in_data_byte,
  input  logic                       in_channel_sel,
  input  logic                       in_block_start,
  input  logic signed [SAMPLE_W-1:0] in_init_predictor,
  input  logic [IDX_W-1:0]           in_init_index,
  input  logic                       in_block_last,
  output logic signed [SAMPLE_W-1:0] out_first_sample,
  output logic signed [SAMPLE_W-1:0] out_second_sample,
  output logic                       out_sample_channel,
  output logic                       out_last_in_block
);

  // latched beat
  logic [7:0]                 byte_r;
  logic                       ch_r;
  logic                       start_r;
  logic signed [SAMPLE_W-1:0] seed_pred_r;
  logic [IDX_W-1:0]           seed_idx_r;
  logic                       last_r;
  logic signed [SAMPLE_W-1:0] first_r;

  // channel state
  logic signed [SAMPLE_W-1:0] pred_r [CHANS];
  logic [IDX_W-1:0]           idx_r  [CHANS];

  // output register
  logic signed [SAMPLE_W-1:0] out_first_r, out_second_r;
  logic                       out_ch_r, out_last_r;

  logic signed [SAMPLE_W-1:0] cur_pred;
  logic [IDX_W-1:0]           cur_idx;
  logic [3:0]                 nib;
  logic [STEP_W-1:0]          step;
  logic [STEP_W+3:0]          prod;
  logic [STEP_W-1:0]          diff;
  logic signed [SAMPLE_W+1:0] sum;
  logic signed [SAMPLE_W-1:0] new_pred;
  logic signed [4:0]          idx_adj;
  logic signed [IDX_W+1:0]    idx_sum;
  logic [IDX_W-1:0]           new_idx;
  logic [IDX_W-1:0]           seed_idx_sat;

  assign seed_idx_sat = (in_init_index > IDX_MAX) ? IDX_MAX : in_init_index;

  // seed applies only to the low nibble; the high nibble reads the committed state
  always_comb begin
    if (cmd.step_lo && start_r) begin
      cur_pred = seed_pred_r;
      cur_idx  = seed_idx_r;
    end else begin
      cur_pred = pred_r[ch_r];
      cur_idx  = idx_r[ch_r];
    end
    nib = cmd.step_lo ? byte_r[3:0] : byte_r[7:4];
  end

  always_comb begin
    step = step_size(cur_idx);
    prod = {15'd0, nib[2:0], 1'b1} * {4'd0, step};
    diff = prod[STEP_W+3:4];
    if (nib[3]) sum = {{2{cur_pred[SAMPLE_W-1]}}, cur_pred} - {3'b000, diff};
    else        sum = {{2{cur_pred[SAMPLE_W-1]}}, cur_pred} + {3'b000, diff};
    if (sum > $signed({{2{SAMPLE_MAX[SAMPLE_W-1]}}, SAMPLE_MAX}))
      new_pred = SAMPLE_MAX;
    else if (sum < $signed({{2{SAMPLE_MIN[SAMPLE_W-1]}}, SAMPLE_MIN}))
      new_pred = SAMPLE_MIN;
    else
      new_pred = sum[SAMPLE_W-1:0];
    idx_adj = idx_adjust(nib[2:0]);
    idx_sum = $signed({2'b00, cur_idx}) + {{4{idx_adj[4]}}, idx_adj};
    if (idx_sum < 0)
      new_idx = '0;
    else if (idx_sum > $signed({2'b00, IDX_MAX}))
      new_idx = IDX_MAX;
    else
      new_idx = idx_sum[IDX_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (cmd.latch_in) begin
      byte_r      <= in_data_byte;
      ch_r        <= in_channel_sel;
      start_r     <= in_block_start;
      seed_pred_r <= in_init_predictor;
      seed_idx_r  <= seed_idx_sat;
      last_r      <= in_block_last;
    end
    if (cmd.step_lo) first_r <= new_pred;
    if (cmd.load_out) begin
      out_first_r  <= first_r;
      out_second_r <= new_pred;
      out_ch_r     <= ch_r;
      out_last_r   <= last_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < CHANS; i++) begin
        pred_r[i] <= '0;
        idx_r[i]  <= '0;
      end
    end else if (cmd.step_lo || cmd.load_out) begin
      pred_r[ch_r] <= new_pred;
      idx_r[ch_r]  <= new_idx;
    end
  end

  assign out_first_sample   = out_first_r;
  assign out_second_sample  = out_second_r;
  assign out_sample_channel = out_ch_r;
  assign out_last_in_block  = out_last_r;

endmodule

FILE: design/ima_adpcm_nibble_decoder_core.sv
// ----------------------------------------------------------------------------
// ima_adpcm_nibble_decoder_core
// IMA ADPCM byte decoder (x>>4 difference variant), two channel states.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready): one compressed byte per beat, with its
//   channel select, block start flag, seed predictor/index and block end flag.
//   On block start the selected channel is seeded (index saturated to 88)
//   before the low nibble is decoded.
//   Output channel (out_valid/out_ready): one beat per input byte, carrying
//   the low-nibble sample, the high-nibble sample, channel and block end.
// Flow: latch the byte, decode its low nibble, then its high nibble while
//   filling the output register once free; one nibble per cycle on the
//   shared decoder unless the high step waits. A new byte is taken as that
//   step ends, by the serial dependency via channel predictor and step index.
// Reset: synchronous, active low; both channel states return to predictor 0
//   and index 0, out_valid drops, the sequencer goes idle.
// Stall: while out_ready is low a held result stays put. The next byte is
//   still taken and its low nibble decoded; the high nibble step then waits
//   until the output register drains, and in_ready stays low meanwhile.
// ----------------------------------------------------------------------------
module ima_adpcm_nibble_decoder_core
  import imadec_pkg::*;
(
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [7:0]                 in_data_byte,
  input  logic                       in_channel_sel,
  input  logic                       in_block_start,
  input  logic signed [SAMPLE_W-1:0] in_init_predictor,
  input  logic [IDX_W-1:0]           in_init_index,
  input  logic                       in_block_last,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic signed [SAMPLE_W-1:0] out_first_sample,
  output logic signed [SAMPLE_W-1:0] out_second_sample,
  output logic                       out_sample_channel,
  output logic                       out_last_in_block
);

  dp_cmd_t cmd;

  // sequencer: idle -> low nibble -> high nibble (waits for output slot)
  imadec_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd)
  );

  // datapath: beat latch, channel state, nibble decoder, output register
  imadec_dp u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .cmd                (cmd),
    .in_data_byte       (in_data_byte),
    .in_channel_sel     (in_channel_sel),
    .in_block_start     (in_block_start),
    .in_init_predictor  (in_init_predictor),
    .in_init_index      (in_init_index),
    .in_block_last      (in_block_last),
    .out_first_sample   (out_first_sample),
    .out_second_sample  (out_second_sample),
    .out_sample_channel (out_sample_channel),
    .out_last_in_block  (out_last_in_block)
  );

endmodule

FILE: design/imadec_checker.sv
// ----------------------------------------------------------------------------
// imadec_checker
// Port-level checks for the nibble decoder, bound to the top level.
// ----------------------------------------------------------------------------
module imadec_checker
  import imadec_pkg::*;
(
  input logic                       clk,
  input logic                       rst_n,
  input logic                       in_valid,
  input logic                       in_ready,
  input logic                       out_valid,
  input logic                       out_ready,
  input logic signed [SAMPLE_W-1:0] out_first_sample,
  input logic signed [SAMPLE_W-1:0] out_second_sample
);

  // held result stays up
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("out_valid dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_first_sample) && $stable(out_second_sample))
    else $error("result changed while stalled");

  // no new byte during the low nibble step
  a_busy_lo: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("byte taken during low nibble step");

  // a fresh result follows its byte through the low and high nibble steps
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_valid && in_ready, 3))
    else $error("result without matching input byte");

  // reset leaves the output empty
  a_reset: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("out_valid high after reset");

endmodule

bind ima_adpcm_nibble_decoder_core imadec_checker u_imadec_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .in_valid          (in_valid),
  .in_ready          (in_ready),
  .out_valid         (out_valid),
  .out_ready         (out_ready),
  .out_first_sample  (out_first_sample),
  .out_second_sample (out_second_sample)
);
